// ===== src/clc_pkg.sv =====
// shared constants, types and field widths for the circle/line collision stepper
// depends on nothing; used by every file of the block but clc_ram
package clc_pkg;

  localparam int unsigned MaxEntriesDefault = 128;
  localparam int unsigned PosFracDefault    = 11;

  localparam int unsigned WordW   = 24;
  localparam int unsigned NormW   = 16;
  localparam int unsigned NormFrac = 14;
  localparam int unsigned CfgW    = 8;
  localparam int unsigned CmdW    = 2;
  localparam int unsigned IdxW    = 7;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CmdW-1:0] CmdLoad   = 2'd0;
  localparam logic [CmdW-1:0] CmdSet    = 2'd1;
  localparam logic [CmdW-1:0] CmdStep   = 2'd2;
  localparam logic [CmdW-1:0] CmdUnused = 2'd3;

  localparam logic [CfgIdxW-1:0] RegRadius = 1'd0;
  localparam logic [CfgIdxW-1:0] RegInUse  = 1'd1;

  localparam int unsigned EntryW = 4 * WordW + 2 * NormW + 1;

  typedef struct packed {
    logic [CmdW-1:0]          cmd;
    logic [IdxW-1:0]          entry_index;
    logic                     is_infinite_line;
    logic signed [WordW-1:0]  first_x;
    logic signed [WordW-1:0]  first_y;
    logic signed [WordW-1:0]  second_x;
    logic signed [WordW-1:0]  second_y;
    logic signed [NormW-1:0]  unit_normal_x;
    logic signed [NormW-1:0]  unit_normal_y;
  } in_item_t;

  typedef struct packed {
    logic signed [WordW-1:0] pos_x;
    logic signed [WordW-1:0] pos_y;
    logic signed [WordW-1:0] speed_x_out;
    logic signed [WordW-1:0] speed_y_out;
  } out_item_t;

  // table entry as stored in the memory
  typedef struct packed {
    logic                    line;
    logic signed [WordW-1:0] sx;
    logic signed [WordW-1:0] sy;
    logic signed [WordW-1:0] ex;
    logic signed [WordW-1:0] ey;
    logic signed [NormW-1:0] nx;
    logic signed [NormW-1:0] ny;
  } entry_t;

  // controller to datapath commands
  typedef struct packed {
    logic set_ball;   // load ball from input item
    logic step_start; // latch entry from memory read data
    logic calc;       // advance the per-entry sequence by one phase
    logic move;       // final position += velocity
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic entry_done; // current entry finished
  } dp_status_t;

  function automatic logic signed [WordW-1:0] sat24(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd8388607;
    lo = -64'sd8388608;
    if (v > hi) begin
      sat24 = 24'sh7fffff;
    end else if (v < lo) begin
      sat24 = 24'sh800000;
    end else begin
      sat24 = v[WordW-1:0];
    end
  endfunction

endpackage

// ===== src/clc_stream_if.sv =====
// valid/ready channel carrying one payload of a given type
// depends on clc_pkg for the payload types
interface clc_stream_if #(
  parameter type payload_t = clc_pkg::in_item_t
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/clc_ram.sv =====
// generic single-port write, single-port registered read memory
// no package dependency
module clc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// ===== src/clc_datapath.sv =====
// ball state and per-entry collision arithmetic, one shared product per cycle
// plus the two tangential products of a bounce; depends on clc_pkg
module clc_datapath #(
  parameter int unsigned PosFrac = clc_pkg::PosFracDefault
) (
  input  logic                              clk,
  input  logic                              rst,
  input  clc_pkg::dp_cmd_t                  cmd,
  output clc_pkg::dp_status_t               status,
  input  clc_pkg::in_item_t                 item,
  input  clc_pkg::entry_t                   entry,
  input  logic [clc_pkg::CfgW-1:0]          radius,
  output clc_pkg::out_item_t                ball
);
  localparam int unsigned Sh = 2 * clc_pkg::NormFrac;

  // phase codes of the per-entry sequence
  localparam logic [3:0] PhDx   = 4'd0;
  localparam logic [3:0] PhM1   = 4'd1;
  localparam logic [3:0] PhM2   = 4'd2;
  localparam logic [3:0] PhM3   = 4'd3;
  localparam logic [3:0] PhM4   = 4'd4;
  localparam logic [3:0] PhM5   = 4'd5;
  localparam logic [3:0] PhM6   = 4'd6;
  localparam logic [3:0] PhTest = 4'd7;
  localparam logic [3:0] PhPx   = 4'd8;
  localparam logic [3:0] PhPy   = 4'd9;
  localparam logic [3:0] PhV1   = 4'd10;
  localparam logic [3:0] PhV2   = 4'd11;
  localparam logic [3:0] PhV3   = 4'd12;
  localparam logic [3:0] PhV4   = 4'd13;
  localparam logic [3:0] PhRefl = 4'd14;
  localparam logic [3:0] PhVy   = 4'd15;

  logic signed [clc_pkg::WordW-1:0] px, py, vx, vy;
  clc_pkg::entry_t ent;
  logic [3:0] ph;
  logic signed [clc_pkg::WordW:0] dx, dy, ex, ey;
  logic signed [42:0] dis, t1, t2, sn, st;
  logic signed [42:0] acc;
  logic signed [42:0] depth;
  logic signed [63:0] prod;
  logic signed [40:0] mul_a;
  logic signed [clc_pkg::NormW-1:0] mul_b;
  logic signed [42:0] rr;
  logic signed [42:0] abs_dis;
  logic touched, refl, last;
  logic signed [63:0] rnd;
  logic signed [63:0] racc;
  // the st terms of the reflection, handled in the final phase
  logic signed [63:0] stx, sty;
  logic signed [63:0] refl_x, refl_y;

  assign rr = 43'(radius) <<< (PosFrac + clc_pkg::NormFrac);
  assign abs_dis = dis[42] ? -dis : dis;

  // one shared multiplier, operands picked by phase
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ph)
      PhM1: begin mul_a = 41'(dx); mul_b = ent.nx; end
      PhM2: begin mul_a = 41'(dy); mul_b = ent.ny; end
      PhM3: begin mul_a = 41'(dy); mul_b = ent.nx; end
      PhM4: begin mul_a = 41'(dx); mul_b = ent.ny; end
      PhM5: begin mul_a = 41'(ey); mul_b = ent.nx; end
      PhM6: begin mul_a = 41'(ex); mul_b = ent.ny; end
      PhPx: begin mul_a = 41'(depth); mul_b = ent.nx; end
      PhPy: begin mul_a = 41'(depth); mul_b = ent.ny; end
      PhV1: begin mul_a = 41'(vx); mul_b = ent.nx; end
      PhV2: begin mul_a = 41'(vy); mul_b = ent.ny; end
      PhV3: begin mul_a = 41'(vx); mul_b = ent.ny; end
      PhV4: begin mul_a = 41'(vy); mul_b = ent.nx; end
      PhRefl: begin mul_a = sn[40:0]; mul_b = ent.nx; end
      PhVy: begin mul_a = sn[40:0]; mul_b = ent.ny; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign prod = 64'(mul_a) * 64'(mul_b);

  function automatic logic signed [63:0] rshift(input logic signed [63:0] v);
    rshift = (v + (64'sd1 <<< (Sh - 1))) >>> Sh;
  endfunction

  assign rnd = rshift(prod);

  assign stx = 64'(st) * 64'(ent.ny);
  assign sty = 64'(st) * 64'(ent.nx);
  assign refl_x = rshift(racc + stx);
  assign refl_y = rshift(-prod - sty);

  // contact test, bounce test and end of the sequence for the current entry
  always_comb begin
    touched = (dis <= rr) && (dis >= -rr) && (ent.line || (t1 <= 0 && t2 >= 0));
    if (ent.line) refl = sn[42];
    else refl = (!dis[42] && sn[42]) || (dis[42] && !sn[42] && sn != 0);
    last = ((ph == PhTest) && !touched) || ((ph == PhV4) && !refl) || (ph == PhVy);
  end

  always_ff @(posedge clk) begin
    status.entry_done <= !rst && cmd.calc && last;
    if (rst) begin
      px <= '0; py <= '0; vx <= '0; vy <= '0;
      ph <= PhDx;
    end else if (cmd.set_ball) begin
      px <= item.first_x; py <= item.first_y;
      vx <= item.second_x; vy <= item.second_y;
    end else if (cmd.move) begin
      px <= clc_pkg::sat24(64'(px) + 64'(vx));
      py <= clc_pkg::sat24(64'(py) + 64'(vy));
    end else if (cmd.step_start) begin
      ent <= entry;
      ph <= PhDx;
    end else if (cmd.calc) begin
      ph <= last ? PhDx : ph + 4'd1;
      case (ph)
        PhDx: begin
          dx <= 25'(px) - 25'(ent.sx);
          dy <= 25'(py) - 25'(ent.sy);
          ex <= 25'(px) - 25'(ent.ex);
          ey <= 25'(py) - 25'(ent.ey);
        end
        PhM1: acc <= prod[42:0];
        PhM2: dis <= acc + prod[42:0];
        PhM3: acc <= prod[42:0];
        PhM4: t1 <= acc - prod[42:0];
        PhM5: acc <= prod[42:0];
        PhM6: t2 <= acc - prod[42:0];
        PhTest: depth <= (!ent.line && dis[42]) ? -(rr - abs_dis) : (rr - abs_dis);
        PhPx: px <= clc_pkg::sat24(64'(px) + rnd);
        PhPy: py <= clc_pkg::sat24(64'(py) + rnd);
        PhV1: acc <= prod[42:0];
        PhV2: sn <= acc + prod[42:0];
        PhV3: acc <= prod[42:0];
        PhV4: st <= acc - prod[42:0];
        PhRefl: racc <= -prod;
        PhVy: begin
          vx <= clc_pkg::sat24(refl_x);
          vy <= clc_pkg::sat24(refl_y);
        end
        default: ;
      endcase
    end
  end

  assign ball.pos_x = px;
  assign ball.pos_y = py;
  assign ball.speed_x_out = vx;
  assign ball.speed_y_out = vy;
endmodule

// ===== src/clc_ctrl.sv =====
// sequencer: accepts items, walks table entries, presents results
// depends on clc_pkg
module clc_ctrl #(
  parameter int unsigned MaxEntries = clc_pkg::MaxEntriesDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  clc_pkg::in_item_t             item,
  input  logic                          out_ready,
  output logic                          out_valid,
  input  logic [clc_pkg::CfgW-1:0]      in_use,
  output logic [$clog2(MaxEntries)-1:0] rd_addr,
  output clc_pkg::dp_cmd_t              cmd,
  input  clc_pkg::dp_status_t           status
);
  localparam int unsigned AW = $clog2(MaxEntries);
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRead = 3'd1;
  localparam logic [2:0] StLat  = 3'd2;
  localparam logic [2:0] StCalc = 3'd3;
  localparam logic [2:0] StMove = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  logic [2:0] state;
  logic [AW:0] idx, count;
  logic accept;

  assign in_ready = (state == StIdle);
  assign accept = in_valid && in_ready;
  assign out_valid = (state == StOut);
  assign rd_addr = idx[AW-1:0];
  assign count = (32'(in_use) > MaxEntries) ? (AW+1)'(MaxEntries) : (AW+1)'(in_use);

  always_comb begin
    cmd = '0;
    cmd.set_ball = accept && item.cmd == clc_pkg::CmdSet;
    cmd.step_start = (state == StLat);
    cmd.calc = (state == StCalc);
    cmd.move = (state == StMove);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      idx <= '0;
    end else begin
      case (state)
        StIdle: if (accept && item.cmd == clc_pkg::CmdStep) begin
          idx <= '0;
          state <= StRead;
        end
        StRead: state <= (idx >= count) ? StMove : StLat;
        StLat: state <= StCalc;
        StCalc: if (status.entry_done) begin
          idx <= idx + 1'b1;
          state <= StRead;
        end
        StMove: state <= StOut;
        StOut: if (out_ready) state <= StIdle;
        default: state <= StIdle;
      endcase
    end
  end
endmodule

// ===== src/circle_line_collision_step.sv =====
// top level of the ball and obstacle collision stepper
// depends on clc_pkg, clc_stream_if, clc_ram, clc_ctrl, clc_datapath
//
// usage
//  - in_ch carries load (cmd 0), set (cmd 1) and step (cmd 2) transactions
//  - load writes an obstacle table entry, set places the ball; neither
//    produces a result
//  - step walks entries 0..min(entries_in_use, MaxEntries)-1 and emits one out_ch transaction
//  - cfg_we/cfg_index/cfg_data write ball_radius (0) and entries_in_use (1)
// sequencing
//  - load and set are taken without leaving idle
//  - a step reads, latches and works through each entry in turn, then moves
//    the ball and shows its result; an entry ends after the contact test when
//    not touched, after the velocity products when pushed without a bounce and
//    after the reflection with a bounce; no new transaction is taken until the
//    result leaves; entries share one multiplier, a product per cycle, and a
//    bounce adds the two tangential products in its last phase
// reset
//  - synchronous active-high rst clears the ball and entries_in_use and sets
//    ball_radius to 10; table contents stay undefined until loaded
// stalls
//  - while a result waits for out_ch ready, no new transaction is taken
module circle_line_collision_step #(
  parameter int unsigned MaxEntries = clc_pkg::MaxEntriesDefault,
  parameter int unsigned PosFrac    = clc_pkg::PosFracDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  clc_stream_if.sink                    in_ch,
  clc_stream_if.source                  out_ch,
  input  logic                          cfg_we,
  input  logic [clc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [clc_pkg::CfgW-1:0]      cfg_data
);
  localparam int unsigned AW = $clog2(MaxEntries);

  logic [clc_pkg::CfgW-1:0] ball_radius, entries_in_use;
  clc_pkg::dp_cmd_t    cmd;
  clc_pkg::dp_status_t status;
  clc_pkg::entry_t     wr_entry, rd_entry;
  logic [AW-1:0]       rd_addr;
  logic                wr_en;
  logic                ram_en;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ball_radius <= 8'd10;
      entries_in_use <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        clc_pkg::RegRadius: ball_radius <= cfg_data;
        clc_pkg::RegInUse: entries_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  // table write on load; slots past the table are dropped
  assign ram_en = 32'(in_ch.data.entry_index) < MaxEntries;
  assign wr_en = in_ch.valid && in_ch.ready && in_ch.data.cmd == clc_pkg::CmdLoad && ram_en;
  assign wr_entry = '{line: in_ch.data.is_infinite_line,
                      sx: in_ch.data.first_x, sy: in_ch.data.first_y,
                      ex: in_ch.data.second_x, ey: in_ch.data.second_y,
                      nx: in_ch.data.unit_normal_x, ny: in_ch.data.unit_normal_y};

  clc_ram #(.Width(clc_pkg::EntryW), .Depth(MaxEntries)) u_ram (
    .clk(clk), .wr_en(wr_en), .wr_addr(AW'(in_ch.data.entry_index)),
    .wr_data(wr_entry), .rd_addr(rd_addr), .rd_data(rd_entry)
  );

  clc_ctrl #(.MaxEntries(MaxEntries)) u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .item(in_ch.data), .out_ready(out_ch.ready), .out_valid(out_ch.valid),
    .in_use(entries_in_use), .rd_addr(rd_addr), .cmd(cmd), .status(status)
  );

  clc_datapath #(.PosFrac(PosFrac)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status), .item(in_ch.data),
    .entry(rd_entry), .radius(ball_radius), .ball(out_ch.data)
  );

`ifndef SYNTHESIS
  // result only leaves while nothing new is taken
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !in_ch.ready) else $error("accept while result pending");
  // result holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> $stable(out_ch.data)) else $error("result changed");
`endif
endmodule
